### rtl/rgbcry_pkg.sv
// Shared types and constants for the RGB to CRY pixel converter.
package rgbcry_pkg;

  localparam int unsigned CompBits  = 8;
  localparam int unsigned NumBits   = 2 * CompBits;
  localparam int unsigned IndexBits = 15;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [CompBits-1:0]  red;
    logic [CompBits-1:0]  green;
    logic [CompBits-1:0]  blue;
    logic [IndexBits-1:0] entry_index;
    logic [CompBits-1:0]  entry_value;
  } in_item_t;

  typedef struct packed {
    logic [CompBits-1:0] color_code;
    logic [CompBits-1:0] intensity;
  } out_item_t;

  // Largest component of a pixel.
  function automatic logic [CompBits-1:0] largest(logic [CompBits-1:0] a,
                                                  logic [CompBits-1:0] b,
                                                  logic [CompBits-1:0] c);
    logic [CompBits-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // c * 255 as (c << 8) - c.
  function automatic logic [NumBits-1:0] scale_comp(logic [CompBits-1:0] c);
    return {c, {CompBits{1'b0}}} - NumBits'(c);
  endfunction

endpackage

### rtl/rgbcry_if.sv
// Valid/ready channel interfaces for pixel input and converted output.
interface rgbcry_in_if import rgbcry_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgbcry_out_if import rgbcry_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/rgb_to_cry_pixel_converter.sv
// RGB to CRY pixel converter: max, restoring-division pipeline and code table.
// A transaction passes an input stage (largest and scaled components), then one
// stage per quotient bit, then the table read, which registers the result.
// Throughput: one transaction per cycle; a stall holds only the occupied stages.
// Reset clears the stage and output valid bits only; code table entries are
// undefined until written by a write transaction.
module rgb_to_cry_pixel_converter import rgbcry_pkg::*; #(
  parameter int unsigned INDEX_BITS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  rgbcry_in_if.sink    pix_i,
  rgbcry_out_if.source res_o
);

  localparam int unsigned TableBits = 3 * INDEX_BITS;
  localparam int unsigned Depth     = 2 ** TableBits;
  localparam int unsigned LastStage = INDEX_BITS;

  typedef struct packed {
    op_e                   op;
    logic                  zero;
    logic [CompBits-1:0]   y;
    logic [NumBits-1:0]    rem_r;
    logic [NumBits-1:0]    rem_g;
    logic [NumBits-1:0]    rem_b;
    logic [INDEX_BITS-1:0] q_r;
    logic [INDEX_BITS-1:0] q_g;
    logic [INDEX_BITS-1:0] q_b;
    logic [TableBits-1:0]  waddr;
    logic [CompBits-1:0]   wdata;
  } stage_t;

  // One restoring step: {quotient bit, new remainder}.
  function automatic logic [NumBits:0] rstep(logic [NumBits-1:0] rem,
                                             logic [NumBits-1:0] dv);
    if (rem >= dv) begin
      return {1'b1, rem - dv};
    end
    return {1'b0, rem};
  endfunction

  function automatic stage_t div_step(stage_t s, int unsigned bitpos);
    stage_t             r;
    logic [NumBits-1:0] dv;
    logic [NumBits:0]   sr;
    logic [NumBits:0]   sg;
    logic [NumBits:0]   sb;
    r  = s;
    dv = NumBits'(s.y) << bitpos;
    sr = rstep(s.rem_r, dv);
    sg = rstep(s.rem_g, dv);
    sb = rstep(s.rem_b, dv);
    r.rem_r = sr[NumBits-1:0];
    r.rem_g = sg[NumBits-1:0];
    r.rem_b = sb[NumBits-1:0];
    r.q_r   = {s.q_r[INDEX_BITS-2:0], sr[NumBits]};
    r.q_g   = {s.q_g[INDEX_BITS-2:0], sg[NumBits]};
    r.q_b   = {s.q_b[INDEX_BITS-2:0], sb[NumBits]};
    return r;
  endfunction

  stage_t               st_d [LastStage+1];
  stage_t               st_q [LastStage+1];
  logic [LastStage:0]   v_q;
  logic [LastStage+1:0] rdy;

  logic                 out_v_q;
  logic [CompBits-1:0]  out_code_q;
  logic [CompBits-1:0]  out_int_q;
  logic [CompBits-1:0]  code_table_q [Depth];

  stage_t               last;
  logic [TableBits-1:0] raddr;
  logic                 do_read;
  logic                 do_write;

  // Ready ripples back from the output register.
  always_comb begin
    rdy[LastStage+1] = !out_v_q || res_o.ready;
    for (int j = LastStage; j >= 0; j--) begin
      rdy[j] = !v_q[j] || rdy[j+1];
    end
  end

  assign pix_i.ready = rdy[0];

  always_comb begin
    st_d[0]       = '0;
    st_d[0].op    = pix_i.data.op;
    st_d[0].y     = largest(pix_i.data.red, pix_i.data.green, pix_i.data.blue);
    st_d[0].zero  = (st_d[0].y == '0);
    st_d[0].rem_r = scale_comp(pix_i.data.red);
    st_d[0].rem_g = scale_comp(pix_i.data.green);
    st_d[0].rem_b = scale_comp(pix_i.data.blue);
    st_d[0].waddr = TableBits'(pix_i.data.entry_index);
    st_d[0].wdata = pix_i.data.entry_value;
    for (int j = 1; j <= LastStage; j++) begin
      st_d[j] = div_step(st_q[j-1], CompBits - j);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int j = 1; j <= LastStage; j++) begin
        if (rdy[j]) begin
          v_q[j] <= v_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= LastStage; j++) begin
      if (rdy[j]) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  assign last     = st_q[LastStage];
  assign raddr    = last.zero ? '0 : {last.q_r, last.q_g, last.q_b};
  assign do_read  = rdy[LastStage+1] && v_q[LastStage] && (last.op == OP_CONVERT);
  assign do_write = rdy[LastStage+1] && v_q[LastStage] && (last.op == OP_WRITE);

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      code_table_q[last.waddr] <= last.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      out_code_q <= code_table_q[raddr];
      out_int_q  <= last.y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy[LastStage+1]) begin
      out_v_q <= do_read;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.data.color_code = out_code_q;
  assign res_o.data.intensity  = out_int_q;

endmodule

### rtl/rgbcry_checker.sv
// Port-level assertions for the RGB to CRY converter, bound to the top level.
module rgbcry_checker import rgbcry_pkg::*; #(
  parameter int unsigned INDEX_BITS = 5
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input op_e       in_op_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  localparam int unsigned MaxPending = INDEX_BITS + 2;

  logic [4:0] pending_q;
  logic       conv_acc;
  logic       res_acc;

  assign conv_acc = in_valid_i && in_ready_i && (in_op_i == OP_CONVERT);
  assign res_acc  = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 5'(conv_acc) - 5'(res_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without a pending convert transaction");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 5'(MaxPending))
    else $error("more convert transactions in flight than pipeline stages");

endmodule

bind rgb_to_cry_pixel_converter rgbcry_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_rgbcry_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .in_op_i     (pix_i.data.op),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
